// ===== src/afsu_pkg.sv =====
// Package for the activation frame stack unit: command and status codes,
// sequencer states and default sizes. No dependencies.
package afsu_pkg;

   localparam int MemDepthDefault     = 1024;
   localparam int FrameDepthDefault   = 64;
   localparam int OperandDepthDefault = 64;
   localparam int ValueBitsDefault    = 32;
   localparam int HeaderSlots         = 3;

   typedef enum logic [3:0] {
      CMD_RESET     = 4'd0,
      CMD_ALLOC     = 4'd1,
      CMD_PUSH_FRM  = 4'd2,
      CMD_POP_FRM   = 4'd3,
      CMD_PUSH      = 4'd4,
      CMD_POP       = 4'd5,
      CMD_PEEK      = 4'd6,
      CMD_LOAD      = 4'd7,
      CMD_STORE     = 4'd8,
      CMD_RESOLVE   = 4'd9
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_UNDERFLOW = 3'd1,
      ST_BAD_ADDR  = 3'd2,
      ST_MEM_FULL  = 3'd3,
      ST_FRM_FULL  = 3'd4,
      ST_OPD_FULL  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_ZERO,
      S_WALK_RD,
      S_WALK_WT,
      S_WALK_CHK,
      S_HDR,
      S_RD_WT,
      S_RD_DONE,
      S_RESP
   } state_type;

endpackage

// ===== src/activation_frame_stack_unit.sv =====
// Activation frame stack unit: slot memory, frame record stack and operand
// stack under one sequencer. Depends on afsu_pkg.
//
// One command beat is taken at a time; req_ready is high only while the unit
// is idle and the previous response has left. Reset, push and store go from
// decode straight to the response state; pop frame, pop, peek and load also
// pass S_RD_WT and S_RD_DONE for the registered memory read. Alloc zeroes its
// new slots one at a time through the single slot memory write port. Push
// frame and resolve follow static links through the slot memory read port,
// one link per S_WALK_CHK, S_WALK_RD and S_WALK_WT round, then push frame
// writes its three header slots. No clearing pass is needed after reset.
module activation_frame_stack_unit #(
   parameter int MEM_DEPTH     = afsu_pkg::MemDepthDefault,
   parameter int FRAME_DEPTH   = afsu_pkg::FrameDepthDefault,
   parameter int OPERAND_DEPTH = afsu_pkg::OperandDepthDefault,
   parameter int VALUE_BITS    = afsu_pkg::ValueBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [3:0]          req_cmd,
   input  logic [10:0]         req_slot_count,
   input  logic [15:0]         req_ret_target,
   input  logic [7:0]          req_nest_level,
   input  logic signed [10:0]  req_mem_addr,
   input  logic [9:0]          req_slot_offset,
   input  logic signed [31:0]  req_data_in,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_data_out,
   output logic [9:0]          rsp_frame_base,
   output logic [10:0]         rsp_used_slots,
   output logic signed [16:0]  rsp_ret_out,
   output logic signed [31:0]  rsp_link_out,
   output logic [9:0]          rsp_dyn_link_out,
   output logic                rsp_operands_empty,
   output logic [2:0]          rsp_status
);
   import afsu_pkg::*;

   localparam int AW  = $clog2(MEM_DEPTH);
   localparam int CW  = AW + 1;
   localparam int FW  = $clog2(FRAME_DEPTH);
   localparam int FCW = FW + 1;
   localparam int OW  = $clog2(OPERAND_DEPTH);
   localparam int OCW = OW + 1;
   localparam int RW  = VALUE_BITS + AW + 16;

   // Memories.
   logic [VALUE_BITS-1:0] slot_mem [MEM_DEPTH];
   logic [RW-1:0]         frame_mem [FRAME_DEPTH];
   logic [VALUE_BITS-1:0] opd_mem [OPERAND_DEPTH];

   state_type state_ff, state_in;

   logic [CW-1:0]  used_ff, used_in;
   logic [AW-1:0]  base_ff, base_in;
   logic [FCW-1:0] fdep_ff, fdep_in;
   logic [OCW-1:0] odep_ff, odep_in;

   // Latched request.
   cmd_type          cmd_ff;
   logic [10:0]      cnt_ff;
   logic [15:0]      ret_ff;
   logic [7:0]       lvl_ff, lvl_in;
   logic signed [10:0] addr_ff;
   logic [9:0]       off_ff;
   logic [31:0]      din_ff;

   // Work registers.
   logic signed [VALUE_BITS-1:0] link_ff, link_in;
   logic [CW-1:0]  ptr_ff, ptr_in;
   logic [1:0]     hdr_ff, hdr_in;

   // Memory ports.
   logic                  sw_en;
   logic [AW-1:0]         sw_addr, sr_addr;
   logic [VALUE_BITS-1:0] sw_data, sr_data_ff;
   logic                  fw_en;
   logic [RW-1:0]         fr_data_ff;
   logic                  ow_en;
   logic [VALUE_BITS-1:0] or_data_ff;

   // Response registers.
   logic                  rv_ff, rv_in;
   logic [31:0]           rd_ff, rd_in;
   logic signed [16:0]    rr_ff, rr_in;
   logic [31:0]           rl_ff, rl_in;
   logic [9:0]            rdl_ff, rdl_in;
   logic [2:0]            rs_ff, rs_in;

   logic accept;
   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign accept    = req_valid && req_ready;

   // A load or store address must be non-negative and below the used slots.
   logic addr_ok, link_in_range, alloc_full;
   assign addr_ok = !addr_ff[10] && (CW'(addr_ff[9:0]) < used_ff);
   assign link_in_range = (link_ff >= 0) &&
                          ($unsigned(link_ff) < VALUE_BITS'(used_ff));

   // The sum can pass the range of the used-slot counter, so it is formed at full integer width.
   assign alloc_full = (32'(used_ff) + 32'(cnt_ff)) > 32'(MEM_DEPTH);

   logic [RW-1:0] frec;
   assign frec = {link_ff, base_ff, ret_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (accept) state_in = S_DECODE;
         S_DECODE: begin
            unique case (cmd_ff)
               CMD_ALLOC:
                  state_in = (alloc_full || cnt_ff == 11'd0) ? S_RESP : S_ZERO;
               CMD_PUSH_FRM:
                  state_in = (fdep_ff >= FCW'(FRAME_DEPTH) ||
                              used_ff + CW'(HeaderSlots) > CW'(MEM_DEPTH))
                             ? S_RESP : S_WALK_CHK;
               CMD_RESOLVE: state_in = S_WALK_CHK;
               CMD_POP_FRM, CMD_POP, CMD_PEEK, CMD_LOAD: state_in = S_RD_WT;
               default:     state_in = S_RESP;
            endcase
         end
         S_ZERO:     if (ptr_ff == CW'(cnt_ff) - CW'(1)) state_in = S_RESP;
         S_WALK_CHK: begin
            if (lvl_ff == 8'd0 || !link_in_range)
               state_in = (cmd_ff == CMD_PUSH_FRM) ? S_HDR : S_RESP;
            else
               state_in = S_WALK_RD;
         end
         S_WALK_RD:  state_in = S_WALK_WT;
         S_WALK_WT:  state_in = S_WALK_CHK;
         S_HDR:      if (hdr_ff == 2'd2) state_in = S_RESP;
         S_RD_WT:    state_in = S_RD_DONE;
         S_RD_DONE:  state_in = S_RESP;
         S_RESP:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      used_in = used_ff; base_in = base_ff; fdep_in = fdep_ff; odep_in = odep_ff;
      lvl_in = lvl_ff; link_in = link_ff; ptr_in = ptr_ff; hdr_in = hdr_ff;
      rv_in = rv_ff; rd_in = rd_ff; rr_in = rr_ff; rl_in = rl_ff;
      rdl_in = rdl_ff; rs_in = rs_ff;
      sw_en = 1'b0; sw_addr = AW'(used_ff + ptr_ff); sw_data = '0;
      sr_addr = link_ff[AW-1:0];
      fw_en = 1'b0; ow_en = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            lvl_in = req_nest_level;
            link_in = VALUE_BITS'(base_ff);
            ptr_in = '0; hdr_in = '0;
            rd_in = '0; rr_in = '0; rl_in = '0; rdl_in = '0; rs_in = ST_OK;
         end
         S_DECODE: begin
            unique case (cmd_ff)
               CMD_RESET: begin
                  used_in = '0; base_in = '0; fdep_in = '0; odep_in = '0;
               end
               CMD_ALLOC:
                  if (alloc_full) rs_in = ST_MEM_FULL;
               CMD_PUSH_FRM:
                  if (fdep_ff >= FCW'(FRAME_DEPTH)) rs_in = ST_FRM_FULL;
                  else if (used_ff + CW'(HeaderSlots) > CW'(MEM_DEPTH))
                     rs_in = ST_MEM_FULL;
               CMD_POP_FRM:
                  if (fdep_ff == '0) begin
                     rr_in = -17'sd1;
                     used_in = '0; base_in = '0; odep_in = '0;
                  end
               CMD_PUSH:
                  if (odep_ff >= OCW'(OPERAND_DEPTH)) rs_in = ST_OPD_FULL;
                  else begin
                     ow_en = 1'b1; odep_in = odep_ff + OCW'(1);
                  end
               CMD_POP, CMD_PEEK:
                  if (odep_ff == '0) rs_in = ST_UNDERFLOW;
               CMD_LOAD:
                  if (!addr_ok) rs_in = ST_BAD_ADDR;
               CMD_STORE:
                  if (!addr_ok) rs_in = ST_BAD_ADDR;
                  else begin
                     sw_en = 1'b1; sw_addr = addr_ff[AW-1:0];
                     sw_data = VALUE_BITS'($signed(din_ff));
                  end
               default: ;
            endcase
         end
         S_ZERO: begin
            sw_en = 1'b1;
            ptr_in = ptr_ff + CW'(1);
            if (ptr_ff == CW'(cnt_ff) - CW'(1)) used_in = used_ff + CW'(cnt_ff);
         end
         S_WALK_CHK: begin
            if (lvl_ff != 8'd0 && !link_in_range) begin
               link_in = '0; lvl_in = '0;
            end
            if (lvl_ff == 8'd0 || !link_in_range) begin
               if (cmd_ff == CMD_RESOLVE)
                  rd_in = 32'((link_in_range || lvl_ff == 8'd0 ? link_ff : '0)
                              + VALUE_BITS'(off_ff));
            end
         end
         S_WALK_RD: ;
         S_WALK_WT: begin
            link_in = $signed(sr_data_ff);
            lvl_in = lvl_ff - 8'd1;
         end
         S_HDR: begin
            sw_en = 1'b1;
            sw_addr = AW'(used_ff + CW'(hdr_ff));
            unique case (hdr_ff)
               2'd0:    sw_data = link_ff;
               2'd1:    sw_data = VALUE_BITS'(base_ff);
               default: sw_data = VALUE_BITS'(ret_ff);
            endcase
            hdr_in = hdr_ff + 2'd1;
            if (hdr_ff == 2'd0) fw_en = 1'b1;
            if (hdr_ff == 2'd2) begin
               base_in = used_ff[AW-1:0];
               used_in = used_ff + CW'(HeaderSlots);
               fdep_in = fdep_ff + FCW'(1);
            end
         end
         S_RD_WT: ;
         S_RD_DONE: begin
            unique case (cmd_ff)
               CMD_POP_FRM: if (fdep_ff != '0) begin
                  fdep_in = fdep_ff - FCW'(1);
                  if (CW'(base_ff) < used_ff) used_in = CW'(base_ff);
                  base_in = fr_data_ff[AW+15:16];
                  rr_in = 17'($unsigned(fr_data_ff[15:0]));
                  rl_in = 32'($signed(fr_data_ff[RW-1:AW+16]));
                  rdl_in = 10'(fr_data_ff[AW+15:16]);
               end
               CMD_POP, CMD_PEEK: if (odep_ff != '0) begin
                  rd_in = 32'(or_data_ff);
                  if (cmd_ff == CMD_POP) odep_in = odep_ff - OCW'(1);
               end
               CMD_LOAD: if (addr_ok) rd_in = 32'(sr_data_ff);
               default: ;
            endcase
         end
         S_RESP: rv_in = 1'b1;
         default: ;
      endcase
      if (state_ff == S_RD_WT || state_ff == S_DECODE) sr_addr = addr_ff[AW-1:0];
      if (state_ff == S_WALK_RD) sr_addr = link_ff[AW-1:0];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff <= '0; base_ff <= '0; fdep_ff <= '0; odep_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in; base_ff <= base_in;
         fdep_ff <= fdep_in; odep_ff <= odep_in;
         rv_ff <= rv_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_cmd); cnt_ff <= req_slot_count;
         ret_ff <= req_ret_target; addr_ff <= req_mem_addr;
         off_ff <= req_slot_offset; din_ff <= req_data_in;
      end
      lvl_ff <= lvl_in; link_ff <= link_in; ptr_ff <= ptr_in; hdr_ff <= hdr_in;
      rd_ff <= rd_in; rr_ff <= rr_in; rl_ff <= rl_in; rdl_ff <= rdl_in;
      rs_ff <= rs_in;
   end

   // Memory ports.
   always_ff @(posedge clock) begin
      if (sw_en) slot_mem[sw_addr] <= sw_data;
      sr_data_ff <= slot_mem[sr_addr];
      if (fw_en) frame_mem[fdep_ff[FW-1:0]] <= frec;
      fr_data_ff <= frame_mem[FW'(fdep_ff - FCW'(1))];
      if (ow_en) opd_mem[odep_ff[OW-1:0]] <= VALUE_BITS'($signed(din_ff));
      or_data_ff <= opd_mem[OW'(odep_ff - OCW'(1))];
   end

   assign rsp_valid          = rv_ff;
   assign rsp_data_out       = rd_ff;
   assign rsp_frame_base     = 10'(base_ff);
   assign rsp_used_slots     = 11'(used_ff);
   assign rsp_ret_out        = rr_ff;
   assign rsp_link_out       = rl_ff;
   assign rsp_dyn_link_out   = rdl_ff;
   assign rsp_operands_empty = (odep_ff == '0);
   assign rsp_status         = rs_ff;

endmodule

// ===== src/afsu_checker.sv =====
// Port-level checks for the activation frame stack unit, bound to its top.
// Depends on afsu_pkg for status codes.
module afsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [10:0] rsp_used_slots
);
   import afsu_pkg::*;

   // A response beat holds until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped");

   // No new command while a response is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready during pending response");

   // A command beat never completes in the next cycle.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid && !req_ready)
      else $error("response too early");

   // Status stays within its defined codes and used slots do not exceed 1024.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_OPD_FULL && rsp_used_slots <= 11'd1024)
      else $error("bad status");

endmodule

bind activation_frame_stack_unit afsu_checker u_afsu_checker (.*);
